// ===== hdl/tpwd_pkg.sv =====
// -----------------------------------------------------------------------------
// tpwd_pkg
// Shared constants, register indexes and the control type of the TDO pattern
// window detector.
// -----------------------------------------------------------------------------
package tpwd_pkg;

  // Longest pattern and window in bits; one window cell per bit.
  localparam int PATTERN_MAX = 64;
  localparam int PAT_W       = 64;
  localparam int LEN_W       = 7;
  localparam int POS_W       = 6;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(34);
  localparam logic [CNT_W-1:0] CLOCK_RESET = CNT_W'(128);
  localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(PATTERN_MAX);
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_COUNT    = CFG_IDX_W'(2);

  // Control from the sequencer to the row of window cells.
  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctl_t;

endpackage

// ===== hdl/tpwd_if.sv =====
// -----------------------------------------------------------------------------
// tpwd_if
// Valid/ready channels of the TDO pattern window detector: samples in,
// results out and configuration writes.
// -----------------------------------------------------------------------------
interface tpwd_in_if;
  logic valid;
  logic ready;
  logic tdo_bit;
  logic seed;
  modport source (output valid, output tdo_bit, output seed, input ready);
  modport sink   (input valid, input tdo_bit, input seed, output ready);
endinterface

interface tpwd_out_if;
  logic       valid;
  logic       ready;
  logic       tdi_bit;
  logic       done_res;
  logic       matched;
  logic [7:0] offset;
  logic [7:0] toggles;
  modport source (output valid, output tdi_bit, output done_res, output matched,
                  output offset, output toggles, input ready);
  modport sink   (input valid, input tdi_bit, input done_res, input matched,
                  input offset, input toggles, output ready);
endinterface

interface tpwd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tpwd_cell.sv =====
// -----------------------------------------------------------------------------
// tpwd_cell
// One bit of the sliding sample window. It takes its neighbour's bit on a
// shift, or the new sample when it is the top cell of the window.
// -----------------------------------------------------------------------------
module tpwd_cell (
  input  logic              clk,
  input  logic              rst,
  input  tpwd_pkg::win_ctl_t ctl,
  input  logic              active,
  input  logic              top,
  input  logic              nbr_bit,
  input  logic              tdo_bit,
  input  logic              pat_bit,
  output logic              bit_q,
  output logic              eq
);
  import tpwd_pkg::*;

  logic shifted;

  // Cells above the window length are masked to zero.
  assign shifted = active ? (top ? tdo_bit : nbr_bit) : 1'b0;

  // Compare is made against the window after this shift.
  assign eq = !active || (shifted == pat_bit);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      bit_q <= 1'b0;
    end else if (ctl.shift) begin
      bit_q <= shifted;
    end
  end

endmodule

// ===== hdl/tpwd_window.sv =====
// -----------------------------------------------------------------------------
// tpwd_window
// Row of window cells. Each cell hands its bit to its lower neighbour on
// every shift; the per-cell compares are reduced to one match flag.
// -----------------------------------------------------------------------------
module tpwd_window (
  input  logic                            clk,
  input  logic                            rst,
  input  tpwd_pkg::win_ctl_t              ctl,
  input  logic [tpwd_pkg::LEN_W-1:0]      len,
  input  logic [tpwd_pkg::PAT_W-1:0]      pattern,
  input  logic                            tdo_bit,
  output logic                            all_eq
);
  import tpwd_pkg::*;

  logic [PATTERN_MAX-1:0] win_bits;
  logic [PATTERN_MAX-1:0] eq_bits;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cells
    logic nbr;
    if (k == PATTERN_MAX - 1) begin : g_last
      assign nbr = 1'b0;
    end else begin : g_mid
      assign nbr = win_bits[k+1];
    end

    tpwd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .active  (LEN_W'(k) < len),
      .top     (len == LEN_W'(k + 1)),
      .nbr_bit (nbr),
      .tdo_bit (tdo_bit),
      .pat_bit (pattern[k]),
      .bit_q   (win_bits[k]),
      .eq      (eq_bits[k])
    );
  end

  assign all_eq = &eq_bits;

endmodule

// ===== hdl/tdo_pattern_window_detector.sv =====
// -----------------------------------------------------------------------------
// tdo_pattern_window_detector
// Drives a configured pattern on a candidate TDI line and looks for it in the
// sampled TDO stream, through a sliding window held in a row of bit cells.
// -----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                   Beat when
//   samples   in         tdo_bit, seed                             valid & ready
//   results   out        tdi_bit, done_res, matched, offset,       valid & ready
//                        toggles
//   cfg       in         index (2 bits), data (64 bits)            valid & ready
//
// Every sample beat yields exactly one result beat, from a registered output
// stage. A new sample is taken in every cycle in which the output stage is
// empty or is being emptied, so the rate is one beat per cycle; the single
// window shift and 64-bit compare set the clock period.
// Reset is synchronous and active high: all registers but the result
// payload return to their defaults and the block idles (every sample answers
// done) until a seed beat arrives. When the result side stalls, the sample
// side stalls with it. The cfg channel is always ready.
// -----------------------------------------------------------------------------
module tdo_pattern_window_detector (
  input  logic       clk,
  input  logic       rst,
  tpwd_in_if.sink    samples,
  tpwd_out_if.source results,
  tpwd_cfg_if.sink   cfg
);
  import tpwd_pkg::*;

  // Configuration registers.
  logic [PAT_W-1:0] pattern_bits;
  logic [LEN_W-1:0] pattern_length;
  logic [CNT_W-1:0] clock_count;

  // Check state.
  logic [CNT_W-1:0] sample_index;
  logic [POS_W-1:0] pattern_position;
  logic             previous_level;
  logic [CNT_W-1:0] toggle_total;
  logic             finished;

  // Output stage.
  logic             out_valid;
  logic             out_tdi;
  logic             out_done;
  logic             out_matched;
  logic [CNT_W-1:0] out_offset;
  logic [CNT_W-1:0] out_toggles;

  logic             accept;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] limit;
  logic [LEN_W-1:0] pos_wrapped;
  logic [LEN_W-1:0] pos_inc;
  logic [POS_W-1:0] pattern_position_next;
  logic [CNT_W-1:0] toggle_total_next;
  logic [CNT_W-1:0] sample_index_next;
  logic             all_eq;
  logic             hit;
  logic             limit_hit;
  win_ctl_t         win_ctl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= '0;
      pattern_length <= LEN_RESET;
      clock_count    <= CLOCK_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_BITS:   pattern_bits   <= cfg.data[PAT_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_W-1:0];
        REG_CLOCK_COUNT:    clock_count    <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero behaves as one, anything beyond the cell count as the
  // full row; a zero clock limit behaves as one.
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > LEN_LIMIT) begin
      len = LEN_LIMIT;
    end else begin
      len = pattern_length;
    end
    limit = (clock_count == '0) ? CNT_W'(1) : clock_count;
  end

  // The next sample may enter whenever the output register will be free.
  assign accept         = samples.valid && samples.ready;
  assign samples.ready  = !out_valid || results.ready;

  assign win_ctl.clear  = accept && samples.seed;
  assign win_ctl.shift  = accept && !samples.seed && !finished;

  tpwd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (win_ctl),
    .len     (len),
    .pattern (pattern_bits),
    .tdo_bit (samples.tdo_bit),
    .all_eq  (all_eq)
  );

  // Pattern position wraps before use, in case the length shrank since the
  // last sample, and again after stepping.
  always_comb begin
    pos_wrapped = ({1'b0, pattern_position} >= len) ? '0 : {1'b0, pattern_position};
    pos_inc     = pos_wrapped + LEN_W'(1);
    pattern_position_next = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];

    if (samples.tdo_bit != previous_level && toggle_total != CNT_MAX) begin
      toggle_total_next = toggle_total + CNT_W'(1);
    end else begin
      toggle_total_next = toggle_total;
    end

    sample_index_next = (sample_index == CNT_MAX) ? sample_index
                                                  : sample_index + CNT_W'(1);

    // A match wins over the clock limit when both fall on the same sample.
    hit       = (sample_index_next >= CNT_W'(len)) && all_eq;
    limit_hit = sample_index_next >= limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index     <= '0;
      pattern_position <= '0;
      previous_level   <= 1'b0;
      toggle_total     <= '0;
      finished         <= 1'b1;
    end else if (accept) begin
      if (samples.seed) begin
        sample_index     <= '0;
        pattern_position <= '0;
        previous_level   <= samples.tdo_bit;
        toggle_total     <= '0;
        finished         <= 1'b0;
      end else if (!finished) begin
        sample_index     <= sample_index_next;
        pattern_position <= pattern_position_next;
        previous_level   <= samples.tdo_bit;
        toggle_total     <= toggle_total_next;
        finished         <= hit || limit_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; loaded on each sample beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdi     <= 1'b0;
      out_done    <= 1'b0;
      out_matched <= 1'b0;
      out_offset  <= '0;
      out_toggles <= '0;
      if (samples.seed) begin
        out_tdi <= pattern_bits[0];
      end else if (finished) begin
        out_done <= 1'b1;
      end else if (hit) begin
        out_done    <= 1'b1;
        out_matched <= 1'b1;
        out_offset  <= sample_index_next - CNT_W'(len);
      end else if (limit_hit) begin
        out_done    <= 1'b1;
        out_toggles <= (toggle_total_next > CNT_W'(1)) ? toggle_total_next : '0;
      end else begin
        out_tdi <= pattern_bits[pattern_position_next];
      end
    end
  end

  assign results.valid    = out_valid;
  assign results.tdi_bit  = out_tdi;
  assign results.done_res = out_done;
  assign results.matched  = out_matched;
  assign results.offset   = out_offset;
  assign results.toggles  = out_toggles;

  // Every sample beat leaves a result waiting in the next cycle.
  a_beat_gives_result : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("sample beat did not produce a result");

  // A match always ends the check.
  a_match_is_done : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_matched |-> out_done)
    else $error("match reported without done");

  // Nothing is driven on TDI once the check has ended.
  a_done_no_tdi : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> !out_tdi)
    else $error("TDI bit driven on a done result");

  // Only a seed beat can restart a finished check.
  a_finished_holds : assert property (@(posedge clk) disable iff (rst)
    finished && !(accept && samples.seed) |=> finished)
    else $error("check restarted without a seed");

  // A result that ends the check leaves the block finished.
  a_end_sets_finished : assert property (@(posedge clk) disable iff (rst)
    accept && !samples.seed && !finished && (hit || limit_hit) |=> finished)
    else $error("check ended but block not finished");

endmodule
